@@ hdl/tcs_pkg.sv @@
`timescale 1ns / 1ps
// Package for the triangle contour segment block.
// Holds payload structs, job and request structs, state enums and constants.
package tcs_pkg;

    localparam int MAX_LEVELS_DEF = 64;
    localparam int JOB_DEPTH      = 2;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] v0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] v1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] v2;
    } t_in;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] level;
        logic               last;
        logic               clipped;
    } t_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] v;
    } t_vtx;

    typedef struct packed {
        t_vtx               vmin;
        t_vtx               vmid;
        t_vtx               vmax;
        logic signed [33:0] first;
        logic [31:0]        stepq;
        logic               clip;
    } t_job;

    typedef struct packed {
        logic signed [31:0] base;
        logic signed [31:0] other;
        logic [31:0]        num;
        logic [31:0]        den;
    } t_edge_req;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV,
        FS_FIRST,
        FS_CLIP,
        FS_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_START,
        BS_WAIT,
        BS_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        ES_IDLE,
        ES_MUL,
        ES_DIV,
        ES_FIN
    } t_edge_state;

endpackage

@@ hdl/triangle_contour_segments.sv @@
`timescale 1ns / 1ps
// The front end sorts the vertices, finds the first level by serial division and the clip
// flag, and pushes the job; it drops a triangle whose first level is above its top value.
// The back end builds each segment's start and end points one coordinate at a time via one
// shared divider; a point on an edge with no value span skips it. The front end takes a new
// triangle only when idle and stalls on a full job queue; segments are paced by the serial
// edge divider and pops. Reset clears all control state; the step register resets to 1.
module triangle_contour_segments #(
    parameter int MAX_LEVELS = tcs_pkg::MAX_LEVELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  tcs_pkg::t_in   i_in,
    output logic           empty,
    input  logic           pop,
    output tcs_pkg::t_out  o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import tcs_pkg::*;

    logic [15:0] r_step;
    logic [31:0] stepq;
    logic        jq_push, jq_full, jq_pop, jq_empty;
    t_job        job_in, job_out;

    assign o_cfg_ready = 1'b1;
    assign stepq = {(r_step == 16'd0) ? 16'd1 : r_step, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_step <= i_cfg_data;
        end
    end

    tcs_front #(.MaxLevels(MAX_LEVELS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in       (i_in),
        .i_stepq    (stepq),
        .o_job_push (jq_push),
        .i_job_full (jq_full),
        .o_job      (job_in)
    );

    tcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .o_full  (jq_full),
        .i_job   (job_in),
        .i_pop   (jq_pop),
        .o_empty (jq_empty),
        .o_job   (job_out)
    );

    tcs_back #(.MaxLevels(MAX_LEVELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (jq_empty),
        .o_job_pop   (jq_pop),
        .i_job       (job_out),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("Block not idle after reset.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("Front end did not go busy after taking a request.");

    a_level_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_out.level[15:0] == 16'd0)
        else $error("Contour level is not a whole value.");

endmodule

@@ hdl/tcs_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts a triangle, sorts its vertices by value and finds the
// first contour level and the clip flag. Depends on tcs_pkg.
module tcs_front #(
    parameter int MaxLevels = tcs_pkg::MAX_LEVELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  tcs_pkg::t_in   i_in,
    input  logic [31:0]    i_stepq,
    output logic           o_job_push,
    input  logic           i_job_full,
    output tcs_pkg::t_job  o_job
);
    import tcs_pkg::*;

    localparam int SpanW = 34 + $clog2(MaxLevels + 1);

    t_front_state r_state, n_state;
    t_vtx         r_vmin, r_vmid, r_vmax;
    logic         r_neg;
    logic [31:0]  r_dvd;
    logic [31:0]  r_rem;
    logic [4:0]   r_cnt;
    logic [31:0]  r_stepq;
    logic signed [33:0] r_first;
    logic         r_clip;
    logic [SpanW-1:0] r_span;

    t_vtx         vtx [3];
    logic [1:0]   imin, imax, imid;
    logic [32:0]  rem_sh;
    logic         rem_ge;
    logic signed [33:0] vmin_e, n_first;
    logic signed [SpanW-1:0] clip_lvl, vmax_w;

    always_comb begin
        vtx[0] = '{x: i_in.x0, y: i_in.y0, v: i_in.v0};
        vtx[1] = '{x: i_in.x1, y: i_in.y1, v: i_in.v1};
        vtx[2] = '{x: i_in.x2, y: i_in.y2, v: i_in.v2};
        imax = 2'd0;
        imin = 2'd0;
        if (i_in.v1 > i_in.v0) begin
            imax = 2'd1;
        end
        if (i_in.v1 < i_in.v0) begin
            imin = 2'd1;
        end
        if (i_in.v2 > vtx[imax].v) begin
            imax = 2'd2;
        end
        if (i_in.v2 < vtx[imin].v) begin
            imin = 2'd2;
        end
        imid = (imin == imax) ? 2'd1 : 2'(2'd3 - imin - imax);
    end

    assign rem_sh = {r_rem, r_dvd[31]};
    assign rem_ge = rem_sh >= {1'b0, r_stepq};

    always_comb begin
        vmin_e = 34'(r_vmin.v);
        if (!r_neg) begin
            n_first = (r_rem != 32'd0) ?
                vmin_e + $signed({2'b00, r_stepq}) - $signed({2'b00, r_rem}) : vmin_e;
        end else begin
            n_first = vmin_e + $signed({2'b00, r_rem});
        end
        clip_lvl = SpanW'(r_first) + $signed(r_span);
        vmax_w   = SpanW'(r_vmax.v);
    end

    always_comb begin
        n_state    = r_state;
        o_full     = 1'b1;
        o_job_push = 1'b0;
        case (r_state)
            FS_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_state = FS_DIV;
                end
            end
            FS_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = FS_FIRST;
                end
            end
            FS_FIRST: begin
                n_state = FS_CLIP;
            end
            FS_CLIP: begin
                n_state = (r_first > 34'(r_vmax.v)) ? FS_IDLE : FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    n_state    = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_span <= SpanW'(MaxLevels) * SpanW'(i_stepq);
        case (r_state)
            FS_IDLE: begin
                r_vmin  <= vtx[imin];
                r_vmid  <= vtx[imid];
                r_vmax  <= vtx[imax];
                r_neg   <= vtx[imin].v[31];
                r_dvd   <= vtx[imin].v[31] ? 32'(-33'(vtx[imin].v)) : vtx[imin].v;
                r_rem   <= 32'd0;
                r_cnt   <= 5'd0;
                r_stepq <= i_stepq;
            end
            FS_DIV: begin
                r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_stepq}) : rem_sh[31:0];
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            FS_FIRST: begin
                r_first <= n_first;
            end
            FS_CLIP: begin
                r_clip <= clip_lvl <= vmax_w;
            end
            default: begin
            end
        endcase
    end

    assign o_job = '{vmin: r_vmin, vmid: r_vmid, vmax: r_vmax, first: r_first,
                     stepq: r_stepq, clip: r_clip};

endmodule

@@ hdl/tcs_fifo.sv @@
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Depends on tcs_pkg for the job struct and depth.
module tcs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  tcs_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_empty,
    output tcs_pkg::t_job  o_job
);
    import tcs_pkg::*;

    localparam int AW = $clog2(JOB_DEPTH);

    t_job              r_mem [JOB_DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              wr, rd;

    assign o_full  = r_cnt == (AW+1)'(JOB_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(JOB_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(JOB_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ hdl/tcs_edge.sv @@
`timescale 1ns / 1ps
// Edge interpolation unit: base + round((other - base) * min(num, den) / den), one
// quotient bit per cycle; a zero den returns base. Depends on tcs_pkg.
module tcs_edge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tcs_pkg::t_edge_req  i_req,
    output logic                o_done,
    output logic signed [31:0]  o_res
);
    import tcs_pkg::*;

    t_edge_state        r_state;
    logic               r_done;
    logic               r_neg;
    logic [31:0]        r_mag, r_num, r_den, r_rem;
    logic signed [31:0] r_base, r_res;
    logic [64:0]        r_dvd;
    logic [6:0]         r_cnt;

    logic signed [32:0] delta;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [63:0]        prod;

    assign delta  = 33'(i_req.other) - 33'(i_req.base);
    assign rem_sh = {r_rem, r_dvd[64]};
    assign rem_ge = rem_sh >= {1'b0, r_den};
    assign prod   = r_mag * r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ES_IDLE: begin
                    if (i_start) begin
                        if (i_req.den == 32'd0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= ES_MUL;
                        end
                    end
                end
                ES_MUL: begin
                    r_state <= ES_DIV;
                end
                ES_DIV: begin
                    if (r_cnt == 7'd64) begin
                        r_state <= ES_FIN;
                    end
                end
                ES_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= ES_IDLE;
                end
                default: begin
                    r_state <= ES_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ES_IDLE: begin
                r_res  <= i_req.base;
                r_base <= i_req.base;
                r_neg  <= delta[32];
                r_mag  <= delta[32] ? 32'(-delta) : delta[31:0];
                r_num  <= (i_req.num > i_req.den) ? i_req.den : i_req.num;
                r_den  <= i_req.den;
            end
            ES_MUL: begin
                r_dvd <= {1'b0, prod} + {34'd0, r_den[31:1]};
                r_rem <= 32'd0;
                r_cnt <= 7'd0;
            end
            ES_DIV: begin
                r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
                r_dvd <= {r_dvd[63:0], rem_ge};
                r_cnt <= r_cnt + 7'd1;
            end
            ES_FIN: begin
                r_res <= r_neg ? r_base - $signed(r_dvd[31:0])
                               : r_base + $signed(r_dvd[31:0]);
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ hdl/tcs_back.sv @@
`timescale 1ns / 1ps
// Back end: steps through the contour levels of one job and builds each
// segment's start and end points coordinate by coordinate. Depends on tcs_pkg and tcs_edge.
module tcs_back #(
    parameter int MaxLevels = tcs_pkg::MAX_LEVELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    output logic           o_job_pop,
    input  tcs_pkg::t_job  i_job,
    output logic           o_empty,
    input  logic           i_pop,
    output tcs_pkg::t_out  o_out
);
    import tcs_pkg::*;

    localparam int KW = $clog2(MaxLevels + 1);

    t_back_state        r_state, n_state;
    t_job               r_job;
    logic signed [33:0] r_lvl;
    logic [KW-1:0]      r_k;
    logic [1:0]         r_pt;
    logic signed [31:0] r_pts [4];
    logic               r_ovalid;
    t_out               r_out;

    t_edge_req          req;
    logic               e_start, e_done;
    logic signed [31:0] e_res;
    logic               lt_mid, is_last, load;
    logic [31:0]        nmin, dmm;
    logic signed [34:0] nxt;

    always_comb begin
        lt_mid  = r_lvl < 34'(r_job.vmid.v);
        nmin    = 32'(r_lvl - 34'(r_job.vmin.v));
        dmm     = 32'(33'(r_job.vmax.v) - 33'(r_job.vmin.v));
        nxt     = 35'(r_lvl) + $signed({3'b000, r_job.stepq});
        is_last = (r_k == KW'(MaxLevels - 1)) || (nxt > 35'(r_job.vmax.v));
        req.num = nmin;
        req.den = dmm;
        case (r_pt)
            2'd0: begin
                req.base  = r_job.vmin.x;
                req.other = r_job.vmax.x;
            end
            2'd1: begin
                req.base  = r_job.vmin.y;
                req.other = r_job.vmax.y;
            end
            default: begin
                if (lt_mid) begin
                    req.base  = (r_pt == 2'd2) ? r_job.vmin.x : r_job.vmin.y;
                    req.other = (r_pt == 2'd2) ? r_job.vmid.x : r_job.vmid.y;
                    req.den   = 32'(33'(r_job.vmid.v) - 33'(r_job.vmin.v));
                end else begin
                    req.base  = (r_pt == 2'd2) ? r_job.vmax.x : r_job.vmax.y;
                    req.other = (r_pt == 2'd2) ? r_job.vmid.x : r_job.vmid.y;
                    req.num   = 32'(34'(r_job.vmax.v) - r_lvl);
                    req.den   = 32'(33'(r_job.vmax.v) - 33'(r_job.vmid.v));
                end
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        e_start   = 1'b0;
        load      = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = BS_START;
                end
            end
            BS_START: begin
                e_start = 1'b1;
                n_state = BS_WAIT;
            end
            BS_WAIT: begin
                if (e_done) begin
                    n_state = (r_pt == 2'd3) ? BS_OUT : BS_START;
                end
            end
            BS_OUT: begin
                if (!r_ovalid || i_pop) begin
                    load    = 1'b1;
                    n_state = is_last ? BS_IDLE : BS_START;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    tcs_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (e_start),
        .i_req   (req),
        .o_done  (e_done),
        .o_res   (e_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_lvl <= i_job.first;
            r_k   <= '0;
            r_pt  <= 2'd0;
        end
        if (r_state == BS_WAIT && e_done) begin
            r_pts[r_pt] <= e_res;
            r_pt        <= r_pt + 2'd1;
        end
        if (load) begin
            r_out <= '{start_x: r_pts[0], start_y: r_pts[1], end_x: r_pts[2],
                       end_y: r_pts[3], level: 32'(r_lvl), last: is_last,
                       clipped: r_job.clip};
            r_lvl <= 34'(nxt);
            r_k   <= r_k + 1'b1;
        end
    end

    assign o_empty = !r_ovalid;
    assign o_out   = r_out;

endmodule
